// File: rtl/spbd_pkg.sv
// Package for the spectrum bar peak decimator: payload structs, register
// indexes, reset values and field widths. No dependencies.
`default_nettype none

package spbd_pkg;

  localparam int unsigned MAG_W     = 15;
  localparam int unsigned PIX_W     = 11;
  localparam int unsigned STEP_W    = 27;
  localparam int unsigned MARGIN_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = STEP_W;

  // Full scale of a Q15 magnitude, the divisor of the height scaling.
  localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;
  localparam logic [PIX_W-1:0] PIX_MAX    = 11'd2047;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BAR_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARGIN = 2'd2;

  // Reset values of the registers.
  localparam logic [STEP_W-1:0]   BAR_STEP_RST    = 27'd131072;
  localparam logic [PIX_W-1:0]    PLOT_HEIGHT_RST = 11'd240;
  localparam logic [MARGIN_W-1:0] LEFT_MARGIN_RST = 8'd6;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_start;
  } spbd_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] bar_x;
    logic [PIX_W-1:0] bar_width;
    logic [PIX_W-1:0] bar_height;
    logic [PIX_W-1:0] bar_top;
    logic             draw;
  } spbd_out_t;

  // A bar that has been decided on but not yet scaled.
  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] width;
    logic [MAG_W-1:0] peak;
  } spbd_bar_t;

endpackage

`default_nettype wire

// File: rtl/spbd_track.sv
// Input register and position/peak tracking stage of the bar decimator.
// Depends on spbd_pkg.
`default_nettype none

module spbd_track #(
  parameter int unsigned FRACTION_BITS = 17
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  spbd_pkg::spbd_in_t                in_data,
  input  wire  [spbd_pkg::STEP_W-1:0]       bar_step,
  input  wire  [spbd_pkg::MARGIN_W-1:0]     left_margin,
  output logic                              bar_valid,
  input  wire                               bar_ready,
  output spbd_pkg::spbd_bar_t               bar_data
);
  import spbd_pkg::*;

  localparam int unsigned POS_W = STEP_W + 1;

  // Input register.
  logic     item_valid;
  spbd_in_t item;

  // Tracking state.
  logic [FRACTION_BITS-1:0] position_fraction;
  logic [MAG_W-1:0]         running_peak;
  logic [PIX_W-1:0]         next_bar_x;

  logic                     advance;
  logic [MAG_W-1:0]         peak_now;
  logic [FRACTION_BITS-1:0] frac_base;
  logic [PIX_W-1:0]         x_base;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         whole;
  logic [PIX_W-1:0]         width_sat;
  logic                     emit;

  assign advance  = item_valid && (!bar_valid || bar_ready);
  assign in_ready = !item_valid || advance;

  always_comb begin
    if (item.frame_start) begin
      peak_now  = item.magnitude;
      frac_base = '0;
      x_base    = PIX_W'(left_margin);
    end else begin
      peak_now  = (item.magnitude > running_peak) ? item.magnitude : running_peak;
      frac_base = position_fraction;
      x_base    = next_bar_x;
    end
    pos       = POS_W'(frac_base) + POS_W'(bar_step);
    whole     = pos >> FRACTION_BITS;
    emit      = (whole != '0);
    width_sat = (whole > POS_W'(PIX_MAX)) ? PIX_MAX : whole[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid        <= 1'b0;
      bar_valid         <= 1'b0;
      position_fraction <= '0;
      running_peak      <= '0;
      next_bar_x        <= PIX_W'(LEFT_MARGIN_RST);
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        bar_valid         <= emit;
        position_fraction <= pos[FRACTION_BITS-1:0];
        if (emit) begin
          running_peak <= '0;
          next_bar_x   <= x_base + width_sat;
        end else begin
          running_peak <= peak_now;
          next_bar_x   <= x_base;
        end
      end else if (bar_ready) begin
        bar_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
    if (advance && emit) begin
      bar_data.x     <= x_base;
      bar_data.width <= width_sat;
      bar_data.peak  <= peak_now;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spbd_scale.sv
// Height scaling and result register of the bar decimator: one 11x15
// multiply, an exact divide by 32767 and the clamp. Depends on spbd_pkg.
`default_nettype none

module spbd_scale (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          bar_valid,
  output logic                         bar_ready,
  input  spbd_pkg::spbd_bar_t          bar_data,
  input  wire  [spbd_pkg::PIX_W-1:0]   plot_height,
  output logic                         out_valid,
  input  wire                          out_ready,
  output spbd_pkg::spbd_out_t          out_data
);
  import spbd_pkg::*;

  localparam int unsigned PROD_W = PIX_W + MAG_W;

  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  quot0;
  logic [MAG_W:0]    rem;
  logic [PIX_W-1:0]  quot;
  logic [PIX_W-1:0]  height;

  // Division by 2^15-1: quotient estimate prod>>15, remainder
  // (prod mod 2^15) + estimate stays below twice the divisor, so one
  // compare corrects it.
  always_comb begin
    prod   = PROD_W'(plot_height) * PROD_W'(bar_data.peak);
    quot0  = prod[PROD_W-1:MAG_W];
    rem    = {1'b0, prod[MAG_W-1:0]} + (MAG_W+1)'(quot0);
    quot   = (rem >= {1'b0, FULL_SCALE}) ? quot0 + 1'b1 : quot0;
    height = (quot >= plot_height) ? plot_height : quot;
  end

  assign bar_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bar_ready) begin
      out_valid <= bar_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bar_ready && bar_valid) begin
      out_data.bar_x      <= bar_data.x;
      out_data.bar_width  <= bar_data.width;
      out_data.bar_height <= height;
      out_data.bar_top    <= plot_height - height;
      out_data.draw       <= (height != '0);
    end
  end

endmodule

`default_nettype wire

// File: rtl/spectrum_bar_peak_decimator.sv
// Top level of the spectrum bar peak decimator: configuration registers
// and the two pipeline stages. Depends on spbd_pkg, spbd_track, spbd_scale.
`default_nettype none

// The block takes one spectrum magnitude per transfer and one transfer per
// clock cycle at full rate; an item passes an input register, a tracking
// stage that advances the fractional position and keeps the peak, and a
// scaling stage with one multiplier feeding the result register, so a bar
// is offered once the sample that completes it has passed through all of them.
// Samples that complete no bar produce no result transfer. Back-pressure
// on the result side propagates through the stages, each of which still
// takes a new item in the cycle its content moves on. Bar height is
// plot_height * peak / 32767, computed exactly and clamped to plot_height.
// A sample flagged as frame start clears the position fraction, returns
// the x position to left_margin and starts the peak at that sample.
// Registers are written through cfg_write/cfg_index/cfg_data: index 0 is
// bar_step, 1 is plot_height, 2 is left_margin; other indexes are ignored.
// They should only be written while no item is in flight.

module spectrum_bar_peak_decimator #(
  parameter int unsigned FRACTION_BITS = 17
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  spbd_pkg::spbd_in_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output spbd_pkg::spbd_out_t                out_data,
  input  wire                                cfg_write,
  input  wire  [spbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [spbd_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import spbd_pkg::*;

  logic [STEP_W-1:0]   bar_step;
  logic [PIX_W-1:0]    plot_height;
  logic [MARGIN_W-1:0] left_margin;

  logic      bar_valid;
  logic      bar_ready;
  spbd_bar_t bar_data;

  // Configuration registers; an unknown index leaves them all unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_step    <= BAR_STEP_RST;
      plot_height <= PLOT_HEIGHT_RST;
      left_margin <= LEFT_MARGIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BAR_STEP:    bar_step    <= cfg_data[STEP_W-1:0];
        REG_PLOT_HEIGHT: plot_height <= cfg_data[PIX_W-1:0];
        REG_LEFT_MARGIN: left_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Position accumulation, peak tracking and the decision to emit a bar.
  spbd_track #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .bar_step    (bar_step),
    .left_margin (left_margin),
    .bar_valid   (bar_valid),
    .bar_ready   (bar_ready),
    .bar_data    (bar_data)
  );

  // Height scaling and the result register.
  spbd_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .bar_valid   (bar_valid),
    .bar_ready   (bar_ready),
    .bar_data    (bar_data),
    .plot_height (plot_height),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for spectrum_bar_peak_decimator: streams spectrum
// samples and register writes, predicts each display bar and compares it.
// Depends on spbd_pkg and the RTL of the block; reads and writes no files.
`timescale 1ns / 100ps

module tb_top;
  import spbd_pkg::*;

  // Fraction width of the position accumulator; matches the block's default.
  localparam int unsigned FRAC_BITS = 17;
  // Index that no register answers to; writes there must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Generous ceiling on the run length in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles allowed after the last bar for samples that produce no bar to
  // leave the pipeline.
  localparam int unsigned SETTLE_CYCLES = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  spbd_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  spbd_out_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  spectrum_bar_peak_decimator #(
    .FRACTION_BITS(FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Samples waiting to be offered, and bars predicted but not yet seen.
  spbd_in_t    pending_samples[$];
  spbd_out_t   expected_bars[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  // Random idling on both sides; switched off for the closing phase.
  bit          idling_on = 1'b1;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;

  // Predictor copy of the registers and of the tracking state. The registers
  // are updated when the testbench writes them, which only happens while the
  // block holds no item.
  logic [STEP_W-1:0]    step_cfg = BAR_STEP_RST;
  logic [PIX_W-1:0]     height_cfg = PLOT_HEIGHT_RST;
  logic [MARGIN_W-1:0]  margin_cfg = LEFT_MARGIN_RST;
  logic [FRAC_BITS-1:0] frac_acc = '0;
  logic [MAG_W-1:0]     peak_hold = '0;
  logic [PIX_W-1:0]     x_next = PIX_W'(LEFT_MARGIN_RST);

  // Advance the bar tracker by one accepted sample and queue the bar that it
  // completes, if any.
  function automatic void predict_bar(input spbd_in_t s);
    logic [STEP_W:0]  pos;
    logic [STEP_W:0]  whole;
    logic [PIX_W-1:0] width;
    int unsigned      scaled;
    spbd_out_t        bar;
    // A frame start rewinds the position before the step is added, and the
    // peak begins at this very sample rather than at zero.
    if (s.frame_start) begin
      frac_acc  = '0;
      x_next    = PIX_W'(margin_cfg);
      peak_hold = s.magnitude;
    end else if (s.magnitude > peak_hold) begin
      peak_hold = s.magnitude;
    end
    pos      = {1'b0, step_cfg} + (STEP_W+1)'(frac_acc);
    whole    = pos >> FRAC_BITS;
    frac_acc = pos[FRAC_BITS-1:0];
    if (whole != '0) begin
      // Widths beyond the pixel field saturate; x then wraps modulo 2048.
      width  = (whole > (STEP_W+1)'(PIX_MAX)) ? PIX_MAX : whole[PIX_W-1:0];
      scaled = (32'(height_cfg) * 32'(peak_hold)) / 32'(FULL_SCALE);
      if (scaled >= 32'(height_cfg))
        scaled = 32'(height_cfg);
      bar.bar_x      = x_next;
      bar.bar_width  = width;
      bar.bar_height = scaled[PIX_W-1:0];
      bar.bar_top    = height_cfg - scaled[PIX_W-1:0];
      bar.draw       = (scaled != 0);
      expected_bars.push_back(bar);
      x_next    = x_next + width;
      peak_hold = '0;
    end
  endfunction

  task automatic compare_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Sample driver: offers queued samples, holds each until its transfer, and
  // inserts idle bursts at random. Each sample is predicted at its transfer.
  always @(posedge clk) begin : sample_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predict_bar(in_data);
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_samples.pop_front();
          if (idling_on && $urandom_range(0, 15) == 0)
            src_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Bar monitor: checks every bar transfer against the oldest prediction and
  // stalls the result side in random bursts.
  always @(posedge clk) begin : bar_monitor
    spbd_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bars.size() == 0) begin
          $error("bar transfer with no bar predicted: x %0d width %0d",
                 out_data.bar_x, out_data.bar_width);
          mismatches++;
        end else begin
          want = expected_bars.pop_front();
          compare_field("bar_x", want.bar_x, out_data.bar_x);
          compare_field("bar_width", want.bar_width, out_data.bar_width);
          compare_field("bar_height", want.bar_height, out_data.bar_height);
          compare_field("bar_top", want.bar_top, out_data.bar_top);
          compare_field("draw", PIX_W'(want.draw), PIX_W'(out_data.draw));
        end
      end
      if (sink_gap != 0)
        sink_gap--;
      else if (idling_on && $urandom_range(0, 11) == 0)
        sink_gap = $urandom_range(1, 13);
      out_ready <= (sink_gap == 0);
    end
  end

  always @(posedge clk) begin : run_watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL spectrum_bar_peak_decimator");
      $finish;
    end
  end

  function automatic void queue_sample(input int unsigned mag, input bit start);
    spbd_in_t s;
    s.magnitude   = mag[MAG_W-1:0];
    s.frame_start = start;
    pending_samples.push_back(s);
  endfunction

  // Magnitudes lean on the extremes now and then, otherwise span the range.
  function automatic int unsigned pick_magnitude();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 32767;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  // One register write; the predictor copy follows at the same edge. The
  // caller lowers the write enable after its last write.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_BAR_STEP:    step_cfg   = val[STEP_W-1:0];
      REG_PLOT_HEIGHT: height_cfg = val[PIX_W-1:0];
      REG_LEFT_MARGIN: margin_cfg = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers plus the unused index. Narrow registers get
  // random upper data bits, which the block must drop.
  task automatic set_config(input logic [STEP_W-1:0] step, input logic [PIX_W-1:0] height,
                            input logic [MARGIN_W-1:0] margin);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom);
    put_reg(REG_BAR_STEP, step);
    put_reg(REG_PLOT_HEIGHT, {junk[CFG_DAT_W-1:PIX_W], height});
    put_reg(REG_LEFT_MARGIN, {junk[CFG_DAT_W-1:MARGIN_W], margin});
    put_reg(REG_UNUSED, CFG_DAT_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  // Waits until every sample has been transferred and every predicted bar has
  // arrived, then lets samples without a bar drain from the pipeline.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_bars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned k;
    int unsigned frame_len;
    int unsigned bins_cfg;
    int unsigned plot_w;
    logic [STEP_W-1:0]   step;
    logic [PIX_W-1:0]    height;
    logic [MARGIN_W-1:0] margin;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, one pixel per sample. The first samples arrive before
    // any frame start and work on the reset state; extremes of magnitude.
    queue_sample(0, 0);
    queue_sample(32767, 0);
    queue_sample(16384, 1);
    queue_sample(1, 0);
    queue_sample(32766, 0);
    queue_sample(0, 1);
    queue_sample(32767, 1);
    wait_drained();

    // Zero step: the position never moves, so no bar, but the peak is kept.
    set_config('0, PIX_MAX, 8'd255);
    queue_sample(32767, 1);
    queue_sample(100, 0);
    queue_sample(7, 0);
    wait_drained();

    // Largest step: very wide bars, so x wraps after a few of them. The first
    // bar still carries the peak held over from the zero-step samples.
    set_config({STEP_W{1'b1}}, PIX_MAX, 8'd255);
    queue_sample(0, 0);
    queue_sample(32767, 0);
    queue_sample(1, 1);
    queue_sample(20000, 0);
    queue_sample(32767, 0);
    wait_drained();

    // Half-pixel step with a zero plot height and margin.
    set_config(STEP_W'(65536), '0, '0);
    queue_sample(32767, 1);
    queue_sample(5, 0);
    queue_sample(32767, 0);
    queue_sample(0, 0);
    wait_drained();

    // A plot one pixel high: heights round down to zero or reach the clamp.
    set_config(STEP_W'(131071), PIX_W'(1), 8'd200);
    queue_sample(16383, 1);
    queue_sample(16384, 0);
    queue_sample(32767, 0);
    wait_drained();

    // Random phases: mostly well-formed frames as long as the bin count the
    // step was worked out for, with stray samples and odd frame lengths.
    for (phase = 0; phase < 8; phase++) begin
      idling_on = (phase < 7);
      bins_cfg  = $urandom_range(8, 128);
      plot_w    = $urandom_range(13, 320);
      case ($urandom_range(0, 9))
        0:       step = '0;
        1:       step = {STEP_W{1'b1}};
        2:       step = STEP_W'($urandom);
        3:       step = STEP_W'($urandom_range(1, 4095));
        default: step = STEP_W'((131072 / bins_cfg) * (plot_w - 12));
      endcase
      case ($urandom_range(0, 4))
        0:       height = '0;
        1:       height = PIX_MAX;
        default: height = PIX_W'($urandom_range(1, 2047));
      endcase
      case ($urandom_range(0, 3))
        0:       margin = '0;
        1:       margin = 8'd255;
        default: margin = MARGIN_W'($urandom_range(0, 255));
      endcase
      set_config(step, height, margin);

      n = 0;
      while (n < 170) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_sample(pick_magnitude(), $urandom_range(0, 1));
          n++;
        end else begin
          frame_len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 200) : bins_cfg;
          for (k = 0; k < frame_len; k++)
            queue_sample(pick_magnitude(), k == 0);
          n += frame_len;
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS spectrum_bar_peak_decimator");
    else
      $display("FAIL spectrum_bar_peak_decimator");
    $finish;
  end

endmodule
